// ===== hdl/line_segment_endpoint_distance_top_macros.svh =====
// assertion macros used by the checker file
`ifndef LINE_SEGMENT_ENDPOINT_DISTANCE_TOP_MACROS_SVH
`define LINE_SEGMENT_ENDPOINT_DISTANCE_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LSED_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsed check failed");

// antecedent implies consequent in the next cycle
`define LSED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsed check failed");

`endif

// ===== hdl/lsed_pkg.sv =====
// shared constants and types for the segment distance block
`default_nettype none
package lsed_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int DIST_BITS   = 17;
    localparam int SAT_W       = 72;
    localparam logic [SAT_W-1:0] SAT_LIMIT = SAT_W'(1) << 60;
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    typedef struct packed {
        logic valid;
        logic sat;
        logic deg;
    } lsed_ctrl_t;
endpackage
`default_nettype wire

// ===== hdl/lsed_if.sv =====
// handshake channels: segment pair in, distance result out
`default_nettype none
interface lsed_in_if #(parameter int CW = lsed_pkg::COORD_WIDTH);
    logic          valid;
    logic          ready;
    logic [CW-1:0] ref_start_x;
    logic [CW-1:0] ref_start_y;
    logic [CW-1:0] ref_end_x;
    logic [CW-1:0] ref_end_y;
    logic [CW-1:0] cand_start_x;
    logic [CW-1:0] cand_start_y;
    logic [CW-1:0] cand_end_x;
    logic [CW-1:0] cand_end_y;
    modport source (output valid, ref_start_x, ref_start_y, ref_end_x, ref_end_y,
                    cand_start_x, cand_start_y, cand_end_x, cand_end_y, input ready);
    modport sink (input valid, ref_start_x, ref_start_y, ref_end_x, ref_end_y,
                  cand_start_x, cand_start_y, cand_end_x, cand_end_y, output ready);
endinterface

interface lsed_out_if;
    logic                           valid;
    logic                           ready;
    logic [lsed_pkg::DIST_BITS-1:0] mean_distance;
    logic                           degenerate;
    modport source (output valid, mean_distance, degenerate, input ready);
    modport sink (input valid, mean_distance, degenerate, output ready);
endinterface
`default_nettype wire

// ===== hdl/line_segment_endpoint_distance_top.sv =====
// throughput: one segment pair per cycle; the whole pipeline holds on output stall
// front: coefficients, numerators, their sum and its square (5 stages)
// root: one registered stage per result bit compares 4*q^2*n against t^2
// reset: rst_n async active low clears every stage valid bit; payload is not reset
`default_nettype none
module line_segment_endpoint_distance_top #(
    parameter int COORD_WIDTH = lsed_pkg::COORD_WIDTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lsed_in_if.sink    in_ch,
    lsed_out_if.source out_ch
);
    localparam int DB    = lsed_pkg::DIST_BITS;
    localparam int CW    = COORD_WIDTH;
    // t^2 on one side, 4 q^2 n on the other
    localparam int CMP_A = 4 * CW + 4;
    localparam int CMP_B = 2 * CW + 2 * DB + 3;
    localparam int CMP_W = (CMP_A > CMP_B) ? CMP_A : CMP_B;

    // global advance: every stage moves together unless the result is stuck
    logic en;

    lsed_pkg::lsed_ctrl_t ctrl_s [0:DB];
    logic [CMP_W-1:0]     t2_s   [0:DB];
    logic [CMP_W-1:0]     n_s    [0:DB];
    logic [CMP_W-1:0]     p_s    [0:DB];
    logic [CMP_W-1:0]     r_s    [0:DB];
    logic [DB-1:0]        q_s    [0:DB];

    assign en          = !ctrl_s[DB].valid || out_ch.ready;
    assign in_ch.ready = en;

    lsed_front #(
        .CW    (CW),
        .CMP_W (CMP_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .valid        (in_ch.valid),
        .ref_start_x  (in_ch.ref_start_x),
        .ref_start_y  (in_ch.ref_start_y),
        .ref_end_x    (in_ch.ref_end_x),
        .ref_end_y    (in_ch.ref_end_y),
        .cand_start_x (in_ch.cand_start_x),
        .cand_start_y (in_ch.cand_start_y),
        .cand_end_x   (in_ch.cand_end_x),
        .cand_end_y   (in_ch.cand_end_y),
        .ctrl         (ctrl_s[0]),
        .t2           (t2_s[0]),
        .n            (n_s[0])
    );

    // running q^2 n and q n start at zero
    assign p_s[0] = '0;
    assign r_s[0] = '0;
    assign q_s[0] = '0;

    // msb first, one result bit per stage
    for (genvar i = 0; i < DB; i++)
    begin : g_root
        lsed_root_stage #(
            .CMP_W (CMP_W),
            .BIT   (DB - 1 - i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctrl_in  (ctrl_s[i]),
            .t2_in    (t2_s[i]),
            .n_in     (n_s[i]),
            .p_in     (p_s[i]),
            .r_in     (r_s[i]),
            .q_in     (q_s[i]),
            .ctrl_out (ctrl_s[i+1]),
            .t2_out   (t2_s[i+1]),
            .n_out    (n_s[i+1]),
            .p_out    (p_s[i+1]),
            .r_out    (r_s[i+1]),
            .q_out    (q_s[i+1])
        );
    end

    // zero-length reference wins over saturation
    assign out_ch.valid         = ctrl_s[DB].valid;
    assign out_ch.degenerate    = ctrl_s[DB].deg;
    assign out_ch.mean_distance = ctrl_s[DB].deg ? '0 :
                                  ctrl_s[DB].sat ? lsed_pkg::DIST_MAX : q_s[DB];
endmodule
`default_nettype wire

// ===== hdl/lsed_front.sv =====
// line coefficients, endpoint numerators, sum and its square over five stages
`default_nettype none
module lsed_front #(
    parameter int CW    = lsed_pkg::COORD_WIDTH,
    parameter int CMP_W = 4 * lsed_pkg::COORD_WIDTH + 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 valid,
    input  wire logic [CW-1:0]        ref_start_x,
    input  wire logic [CW-1:0]        ref_start_y,
    input  wire logic [CW-1:0]        ref_end_x,
    input  wire logic [CW-1:0]        ref_end_y,
    input  wire logic [CW-1:0]        cand_start_x,
    input  wire logic [CW-1:0]        cand_start_y,
    input  wire logic [CW-1:0]        cand_end_x,
    input  wire logic [CW-1:0]        cand_end_y,
    output lsed_pkg::lsed_ctrl_t      ctrl,
    output logic [CMP_W-1:0]          t2,
    output logic [CMP_W-1:0]          n
);
    localparam int NUM_W = 2 * CW + 2;
    localparam int N_W   = 2 * CW + 1;
    localparam int T_W   = 2 * CW + 2;

    logic [4:0] v_reg;

    // stage 1
    logic signed [CW:0]     a_reg, b_reg, a_next, b_next;
    logic signed [2*CW-1:0] p1_reg, p2_reg, p1_next, p2_next;
    logic signed [CW-1:0]   csx_reg, csy_reg, cex_reg, cey_reg;
    // stage 2
    logic signed [2*CW:0]   c_reg, m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [2*CW:0]   c_next, m1_next, m2_next, m3_next, m4_next;
    logic signed [2*CW+1:0] aa_full, bb_full;
    logic [2*CW-1:0]        aa_reg, bb_reg;
    // stage 3
    logic signed [NUM_W-1:0] ns_next, ne_next;
    logic [N_W-1:0]          abs_s_reg, abs_e_reg, abs_s_next, abs_e_next;
    logic [N_W-1:0]          n3_reg, n3_next;
    logic                    deg3_reg;
    // stage 4
    logic [T_W-1:0]          t_reg, t_next;
    logic [N_W-1:0]          n4_reg;
    logic                    deg4_reg, sat4_reg, sat4_next;
    // stage 5
    logic [2*T_W-1:0]        t2_next;
    logic [CMP_W-1:0]        t2_reg, n5_reg;
    logic                    deg5_reg, sat5_reg;

    always_comb
    begin
        a_next  = {ref_end_y[CW-1], ref_end_y} - {ref_start_y[CW-1], ref_start_y};
        b_next  = {ref_start_x[CW-1], ref_start_x} - {ref_end_x[CW-1], ref_end_x};
        p1_next = $signed(ref_end_x) * $signed(ref_start_y);
        p2_next = $signed(ref_start_x) * $signed(ref_end_y);

        c_next  = (2*CW+1)'(p1_reg) - (2*CW+1)'(p2_reg);
        m1_next = a_reg * csx_reg;
        m2_next = b_reg * csy_reg;
        m3_next = a_reg * cex_reg;
        m4_next = b_reg * cey_reg;
        aa_full = a_reg * a_reg;
        bb_full = b_reg * b_reg;

        ns_next    = NUM_W'(m1_reg) + NUM_W'(m2_reg) + NUM_W'(c_reg);
        ne_next    = NUM_W'(m3_reg) + NUM_W'(m4_reg) + NUM_W'(c_reg);
        abs_s_next = ns_next[NUM_W-1] ? N_W'(-ns_next) : N_W'(ns_next);
        abs_e_next = ne_next[NUM_W-1] ? N_W'(-ne_next) : N_W'(ne_next);
        n3_next    = N_W'(aa_reg) + N_W'(bb_reg);

        t_next    = T_W'(abs_s_reg) + T_W'(abs_e_reg);
        sat4_next = lsed_pkg::SAT_W'(t_next) >= lsed_pkg::SAT_LIMIT;

        t2_next = (2*T_W)'(t_reg) * (2*T_W)'(t_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            csx_reg <= cand_start_x;
            csy_reg <= cand_start_y;
            cex_reg <= cand_end_x;
            cey_reg <= cand_end_y;

            c_reg  <= c_next;
            m1_reg <= m1_next;
            m2_reg <= m2_next;
            m3_reg <= m3_next;
            m4_reg <= m4_next;
            aa_reg <= aa_full[2*CW-1:0];
            bb_reg <= bb_full[2*CW-1:0];

            abs_s_reg <= abs_s_next;
            abs_e_reg <= abs_e_next;
            n3_reg    <= n3_next;
            deg3_reg  <= (n3_next == '0);

            t_reg    <= t_next;
            n4_reg   <= n3_reg;
            deg4_reg <= deg3_reg;
            sat4_reg <= sat4_next;

            t2_reg   <= CMP_W'(t2_next);
            n5_reg   <= CMP_W'(n4_reg);
            deg5_reg <= deg4_reg;
            sat5_reg <= sat4_reg;
        end
    end

    assign ctrl.valid = v_reg[4];
    assign ctrl.sat   = sat5_reg;
    assign ctrl.deg   = deg5_reg;
    assign t2         = t2_reg;
    assign n          = n5_reg;
endmodule
`default_nettype wire

// ===== hdl/lsed_root_stage.sv =====
// one quotient bit of floor(t / (2 sqrt(n))) by incremental squares
`default_nettype none
module lsed_root_stage #(
    parameter int CMP_W = 4 * lsed_pkg::COORD_WIDTH + 4,
    parameter int BIT   = 0
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire lsed_pkg::lsed_ctrl_t             ctrl_in,
    input  wire logic [CMP_W-1:0]                 t2_in,
    input  wire logic [CMP_W-1:0]                 n_in,
    input  wire logic [CMP_W-1:0]                 p_in,
    input  wire logic [CMP_W-1:0]                 r_in,
    input  wire logic [lsed_pkg::DIST_BITS-1:0]   q_in,
    output lsed_pkg::lsed_ctrl_t                  ctrl_out,
    output logic [CMP_W-1:0]                      t2_out,
    output logic [CMP_W-1:0]                      n_out,
    output logic [CMP_W-1:0]                      p_out,
    output logic [CMP_W-1:0]                      r_out,
    output logic [lsed_pkg::DIST_BITS-1:0]        q_out
);
    localparam logic [lsed_pkg::DIST_BITS-1:0] BIT_MASK = lsed_pkg::DIST_BITS'(1) << BIT;

    logic [CMP_W-1:0] pc_next;
    logic             take;
    logic             valid_reg;
    logic             sat_reg, deg_reg;
    logic [CMP_W-1:0] t2_reg, n_reg, p_reg, r_reg;
    logic [lsed_pkg::DIST_BITS-1:0] q_reg;

    // (q + 2^k)^2 n = q^2 n + 2^(k+1) q n + 2^(2k) n
    always_comb
    begin
        pc_next = p_in + (r_in << (BIT + 1)) + (n_in << (2 * BIT));
        take    = (pc_next << 2) <= t2_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg <= ctrl_in.sat;
            deg_reg <= ctrl_in.deg;
            t2_reg  <= t2_in;
            n_reg   <= n_in;
            p_reg   <= take ? pc_next : p_in;
            r_reg   <= take ? r_in + (n_in << BIT) : r_in;
            q_reg   <= take ? (q_in | BIT_MASK) : q_in;
        end
    end

    assign ctrl_out.valid = valid_reg;
    assign ctrl_out.sat   = sat_reg;
    assign ctrl_out.deg   = deg_reg;
    assign t2_out = t2_reg;
    assign n_out  = n_reg;
    assign p_out  = p_reg;
    assign r_out  = r_reg;
    assign q_out  = q_reg;
endmodule
`default_nettype wire

// ===== hdl/lsed_checker.sv =====
// port-level checks for the segment distance block, bound to the top level
`default_nettype none
`include "line_segment_endpoint_distance_top_macros.svh"
module lsed_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [lsed_pkg::DIST_BITS-1:0] mean_distance,
    input wire logic                           degenerate
);
    `LSED_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `LSED_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(mean_distance) && $stable(degenerate))
    `LSED_ASSERT_SAME(a_deg_zero, out_valid && degenerate, mean_distance == '0)
    `LSED_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)
endmodule

bind line_segment_endpoint_distance_top lsed_checker u_lsed_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .mean_distance (out_ch.mean_distance),
    .degenerate    (out_ch.degenerate)
);
`default_nettype wire
